>>> rtl/rec_pkg.sv
// Shared types, register indexes and reset constants for the rotary encoder counter.
package rec_pkg;

    localparam int COUNT_W    = 8;
    localparam int TIMER_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX_RST = 8'd100;
    localparam logic [TIMER_W-1:0] DEBOUNCE_RST  = 16'd20;
    localparam logic [COUNT_W-1:0] COUNT_TOP     = 8'd255;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESS   = 2'd1,
        PH_HELD    = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic pin_button;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               led_on;
        logic               cleared;
    } t_out_item;

    // Status from the button sequencer to the encoder counter
    typedef struct packed {
        logic clear;
        logic lamp;
    } t_btn_status;

endpackage

>>> rtl/rec_button.sv
// Button debounce sequencer: press wait, clear, release wait, LED control.
module rec_button
    import rec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_pin_button,
    input  logic [TIMER_W-1:0] i_debounce_ticks,
    output t_btn_status        o_status
);

    t_phase             r_phase, n_phase;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic               r_lamp, n_lamp;
    logic               r_last_button;
    logic               w_fall;
    logic               w_expire;

    assign w_fall   = r_last_button & ~i_pin_button;
    assign w_expire = (r_timer <= TIMER_W'(1));

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_fall) n_phase = PH_PRESS;
            end
            PH_PRESS: begin
                if (w_expire) n_phase = i_pin_button ? PH_IDLE : PH_HELD;
            end
            PH_HELD: begin
                if (i_pin_button) n_phase = PH_RELEASE;
            end
            PH_RELEASE: begin
                if (w_expire) n_phase = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // Timer, lamp and clear request
    always_comb begin
        n_timer         = r_timer;
        n_lamp          = r_lamp;
        o_status.clear  = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_fall) n_timer = i_debounce_ticks;
            end
            PH_PRESS: begin
                n_timer = w_expire ? '0 : r_timer - TIMER_W'(1);
                if (w_expire && !i_pin_button) begin
                    n_lamp         = 1'b1;
                    o_status.clear = 1'b1;
                end
            end
            PH_HELD: begin
                if (i_pin_button) n_timer = i_debounce_ticks;
            end
            PH_RELEASE: begin
                n_timer = w_expire ? '0 : r_timer - TIMER_W'(1);
                if (w_expire) n_lamp = 1'b0;
            end
            default: n_timer = r_timer;
        endcase
        o_status.lamp = n_lamp;
    end

    // Advance state once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_timer       <= '0;
            r_lamp        <= 1'b0;
            r_last_button <= 1'b1;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_timer       <= n_timer;
            r_lamp        <= n_lamp;
            r_last_button <= i_pin_button;
        end
    end

endmodule

>>> rtl/rec_encoder.sv
// Quadrature edge decoder with a saturating count and a button clear.
module rec_encoder
    import rec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_pin_a,
    input  logic               i_pin_b,
    input  logic [COUNT_W-1:0] i_count_max,
    input  t_btn_status        i_status,
    output logic [COUNT_W-1:0] o_count
);

    logic               r_last_a;
    logic               r_last_b;
    logic [COUNT_W-1:0] r_pos, n_pos;
    logic [COUNT_W-1:0] w_pos_a;

    // Apply the A edge (decrement) first, then the B edge (increment)
    always_comb begin
        w_pos_a = r_pos;
        if (r_last_a && !i_pin_a) begin
            if (!i_pin_b && (r_pos != '0)) w_pos_a = r_pos - COUNT_W'(1);
            if (w_pos_a > i_count_max) w_pos_a = i_count_max;
        end
        n_pos = w_pos_a;
        if (r_last_b && !i_pin_b) begin
            if (!i_pin_a && (w_pos_a != COUNT_TOP)) n_pos = w_pos_a + COUNT_W'(1);
            if (n_pos > i_count_max) n_pos = i_count_max;
        end
        if (i_status.clear) n_pos = '0;
    end

    assign o_count = n_pos;

    // Hold the pin history and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a <= 1'b1;
            r_last_b <= 1'b1;
            r_pos    <= '0;
        end else if (i_step) begin
            r_last_a <= i_pin_a;
            r_last_b <= i_pin_b;
            r_pos    <= n_pos;
        end
    end

endmodule

>>> rtl/rotary_encoder_clamped_counter_unit.sv
// Top level of the rotary encoder counter: input register, step logic, result register.
// Each request carries one sample tick of encoder pins A and B and the active-low
// button. A request is registered on acceptance and, once the result register is free,
// passes through the edge decode, saturating count and button sequencer into the result
// register; one result comes out per request, and a new request is taken every cycle
// while results are drained. Input stall rises only when a request sits in the input
// register and the result register is held by a stall.
// Registers count_max (index 0) and debounce_ticks (index 1) are written over the
// configuration port, which is always ready; write them only while the block is idle.
module rotary_encoder_clamped_counter_unit
    import rec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;
    logic [COUNT_W-1:0] r_count_max;
    logic [TIMER_W-1:0] r_debounce;
    logic               w_out_free;
    logic               w_step;
    logic               w_in_take;
    t_btn_status        w_status;
    logic [COUNT_W-1:0] w_count;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_step      = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_max <= COUNT_MAX_RST;
            r_debounce  <= DEBOUNCE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_COUNT_MAX) r_count_max <= i_cfg_data[COUNT_W-1:0];
            if (i_cfg_index == CFG_DEBOUNCE)  r_debounce  <= i_cfg_data[TIMER_W-1:0];
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in;
        end
    end

    rec_button u_button (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_pin_button     (r_in.pin_button),
        .i_debounce_ticks (r_debounce),
        .o_status         (w_status)
    );

    rec_encoder u_encoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_pin_a     (r_in.pin_a),
        .i_pin_b     (r_in.pin_b),
        .i_count_max (r_count_max),
        .i_status    (w_status),
        .o_count     (w_count)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out.count   <= w_count;
            r_out.led_on  <= w_status.lamp;
            r_out.cleared <= w_status.clear;
        end
    end

    // A clearing result shows a zero count with the LED lit
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.cleared) |-> (o_out.count == '0 && o_out.led_on))
        else $error("cleared result without zero count and lit LED");

    // Stall only while a request waits in the input register
    a_stall_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with no pending request");

    // A stepped request always lands in the result register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("stepped request lost");

endmodule

>>> sim/rotary_encoder_clamped_counter_unit_tb.sv
// Self-checking testbench for the rotary encoder counter: quadrature and button stimulus, live prediction.
module rotary_encoder_clamped_counter_unit_tb;
    import rec_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 64;
    localparam int SETTLE      = 4;

    // Indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Ticks as {pin_a, pin_b, pin_button}
    localparam logic [2:0] RESET_TICKS [5] = '{3'b001, 3'b111, 3'b101, 3'b001, 3'b111};
    localparam logic [2:0] EDGE_TICKS [20] = '{
        3'b011, 3'b001, 3'b111, 3'b011, 3'b001, 3'b111, 3'b011, 3'b001,
        3'b110, 3'b000, 3'b111, 3'b110, 3'b111, 3'b110, 3'b111, 3'b110,
        3'b110, 3'b111, 3'b110, 3'b110
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Expected behaviour of the counter and button sequencer
    logic [COUNT_W-1:0] m_limit = COUNT_MAX_RST;
    logic [TIMER_W-1:0] m_debounce = DEBOUNCE_RST;
    logic               m_last_a = 1'b1;
    logic               m_last_b = 1'b1;
    logic               m_last_btn = 1'b1;
    logic [COUNT_W-1:0] m_pos = '0;
    t_phase             m_phase = PH_IDLE;
    logic [TIMER_W-1:0] m_timer = '0;
    logic               m_lamp = 1'b0;

    t_in_item  ticks_to_send [$];
    t_out_item results_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int fails = 0;
    int ticks_sent = 0;
    int results_checked = 0;
    int clears_seen = 0;
    int lit_seen = 0;
    int settings_run = 2;

    logic      got_result = 1'b0;
    t_out_item got_item = '0;
    t_out_item want;

    // Stimulus generator state
    logic gen_a = 1'b1;
    logic gen_b = 1'b1;
    logic gen_btn = 1'b1;
    logic gen_fwd = 1'b1;
    int   btn_run_left = 0;

    rotary_encoder_clamped_counter_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Count one tick of a debounce wait down; true on the tick that ends it
    function automatic logic timer_lapses();
        if (m_timer <= 16'd1) begin
            m_timer = '0;
            return 1'b1;
        end
        m_timer = m_timer - 16'd1;
        return 1'b0;
    endfunction

    // Advance the expected state by one sample tick and return its reading
    function automatic t_out_item next_reading(t_in_item s);
        t_out_item r;
        logic      clr;
        clr = 1'b0;
        // Falling A with B low steps down, applied before B
        if (m_last_a && !s.pin_a) begin
            if (!s.pin_b && m_pos != '0) m_pos = m_pos - 8'd1;
            if (m_pos > m_limit) m_pos = m_limit;
        end
        // Falling B with A low steps up
        if (m_last_b && !s.pin_b) begin
            if (!s.pin_a && m_pos != COUNT_TOP) m_pos = m_pos + 8'd1;
            if (m_pos > m_limit) m_pos = m_limit;
        end
        case (m_phase)
            PH_IDLE: begin
                if (m_last_btn && !s.pin_button) begin
                    m_timer = m_debounce;
                    m_phase = PH_PRESS;
                end
            end
            PH_PRESS: begin
                if (timer_lapses()) begin
                    if (!s.pin_button) begin
                        m_pos = '0;
                        m_lamp = 1'b1;
                        clr = 1'b1;
                        m_phase = PH_HELD;
                    end else begin
                        m_phase = PH_IDLE;
                    end
                end
            end
            PH_HELD: begin
                if (s.pin_button) begin
                    m_timer = m_debounce;
                    m_phase = PH_RELEASE;
                end
            end
            default: begin
                if (timer_lapses()) begin
                    m_lamp = 1'b0;
                    m_phase = PH_IDLE;
                end
            end
        endcase
        m_last_a = s.pin_a;
        m_last_b = s.pin_b;
        m_last_btn = s.pin_button;
        r.count = m_pos;
        r.led_on = m_lamp;
        r.cleared = clr;
        return r;
    endfunction

    // Offer pending ticks; hold the request while stalled, predict on acceptance
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                results_due.push_back(next_reading(in_item));
                void'(ticks_to_send.pop_front());
                ticks_sent++;
            end
            if (in_valid && in_stall) begin
                in_valid <= 1'b1;
            end else if (ticks_to_send.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_item <= ticks_to_send[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random, or for a long stretch on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Capture each accepted result at the edge
    always @(posedge clk) begin
        got_result <= rst_n && out_valid && !out_stall;
        got_item <= out_item;
    end

    // Compare the captured result with the oldest expected reading
    always @(negedge clk) begin
        if (got_result) begin
            if (results_due.size() == 0) begin
                $error("result with no request outstanding: count %0d", got_item.count);
                fails++;
            end else begin
                want = results_due.pop_front();
                if (got_item.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, got_item.count);
                    fails++;
                end
                if (got_item.led_on !== want.led_on) begin
                    $error("led_on: expected %0d, got %0d", want.led_on, got_item.led_on);
                    fails++;
                end
                if (got_item.cleared !== want.cleared) begin
                    $error("cleared: expected %0d, got %0d", want.cleared, got_item.cleared);
                    fails++;
                end
                results_checked++;
                if (want.cleared) clears_seen++;
                if (want.led_on) lit_seen++;
            end
        end
    end

    // Drop the run if it hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("no progress after %0d cycles, %0d results outstanding",
                   cycle_count, results_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Wait until every request is sent and every reading has come back
    task automatic wait_quiet();
        do @(negedge clk);
        while (ticks_to_send.size() != 0 || in_valid || results_due.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_COUNT_MAX) m_limit = data[COUNT_W-1:0];
        else if (idx == CFG_DEBOUNCE) m_debounce = data;
    endtask

    // Mostly clean quadrature steps and debounced button runs, with some noise
    task automatic queue_random_ticks(input int n, input logic [TIMER_W-1:0] deb);
        t_in_item   t;
        int         span;
        int         roll;
        logic [1:0] nxt;
        span = (deb > 16'd30) ? 30 : int'(deb);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 39) == 0) gen_fwd = ~gen_fwd;
            if (btn_run_left == 0) begin
                gen_btn = ~gen_btn;
                btn_run_left = $urandom_range(1, 2 * span + 4);
            end
            btn_run_left--;
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                t = t_in_item'($urandom_range(0, 7));
                gen_a = t.pin_a;
                gen_b = t.pin_b;
            end else begin
                if (roll >= 20) begin
                    case ({gen_a, gen_b})
                        2'b11: nxt = gen_fwd ? 2'b01 : 2'b10;
                        2'b01: nxt = gen_fwd ? 2'b00 : 2'b11;
                        2'b00: nxt = gen_fwd ? 2'b10 : 2'b01;
                        default: nxt = gen_fwd ? 2'b11 : 2'b00;
                    endcase
                    {gen_a, gen_b} = nxt;
                end
                t.pin_a = gen_a;
                t.pin_b = gen_b;
                t.pin_button = gen_btn;
            end
            ticks_to_send.push_back(t);
        end
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] lim, input logic [TIMER_W-1:0] deb,
                             input int s_pct, input int r_pct, input int n,
                             input bit long_hold);
        wait_quiet();
        write_reg(CFG_COUNT_MAX, {8'($urandom), lim});
        write_reg(CFG_DEBOUNCE, deb);
        @(negedge clk);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        queue_random_ticks(n / 2, deb);
        if (long_hold) hold_requests++;
        // Hold the sender back until the first half has fully drained
        wait_quiet();
        queue_random_ticks(n - n / 2, deb);
        settings_run++;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Edges at the reset settings, including a step down at zero
        foreach (RESET_TICKS[k]) ticks_to_send.push_back(t_in_item'(RESET_TICKS[k]));
        wait_quiet();

        // Saturation, clear, release and bounce with a tiny limit and the shortest wait
        write_reg(CFG_COUNT_MAX, 16'd2);
        write_reg(CFG_DEBOUNCE, 16'd1);
        @(negedge clk);
        foreach (EDGE_TICKS[k]) ticks_to_send.push_back(t_in_item'(EDGE_TICKS[k]));

        run_phase(8'd100, 16'd20, 20, 74, 220, 1'b0);
        run_phase(8'd255, 16'd3, 20, 74, 200, 1'b0);
        run_phase(8'd0, 16'd0, 20, 74, 150, 1'b0);
        wait_quiet();
        write_reg(CFG_SPARE, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
        run_phase(8'd1, 16'd1, 74, 20, 200, 1'b0);
        run_phase(8'd7, 16'd5, 74, 20, 200, 1'b0);
        run_phase(8'd200, 16'd2, 0, 0, 300, 1'b1);
        run_phase(8'd255, 16'hFFFF, 0, 0, 150, 1'b0);
        wait_quiet();
        repeat (8) @(posedge clk);

        $display("Checked %0d readings from %0d sample ticks over %0d register settings.",
                 results_checked, ticks_sent, settings_run);
        $display("Button clears seen: %0d; readings with the LED lit: %0d.",
                 clears_seen, lit_seen);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
